// File: sv/pwli_pkg.sv
// shared types and constants of the piecewise linear interpolator
// no dependencies; imported by the channel interfaces, the datapath, the controller, the checker and the top level
package pwli_pkg;

  // field widths
  localparam int LEVEL_W   = 16;  // signed Q8.8 input percentage
  localparam int PCT_Q_W   = 15;  // clamped percentage, 0..25600
  localparam int PCT_W     = 7;   // breakpoint percent, integer
  localparam int SCALE_W   = 20;  // unsigned Q12.8 scale
  localparam int CNT_W     = 3;   // point count register
  localparam int CFG_IDX_W = 3;   // register index
  localparam int CFG_W     = 28;  // widest register
  localparam int PT_SCALE_LSB = 8;
  localparam int FRAC_W    = 8;

  // division: one quotient bit a cycle
  localparam int DIV_STEPS = SCALE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int PROD_W    = SCALE_W + PCT_Q_W;

  localparam logic [PCT_Q_W-1:0] HUNDRED_Q8        = 15'd25600;
  localparam logic [SCALE_W-1:0] DEFAULT_SCALE_RST = 20'd25600;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT   = 3'd0,
    REG_DEFAULT_SCALE = 3'd1,
    REG_POINT_BASE    = 3'd2
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic search;
    logic mult;
    logic div_step;
    logic finish;
  } pwli_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found_const;
    logic found_lerp;
    logic div_last;
  } pwli_stat_t;

endpackage

// File: sv/pwli_channels.sv
// valid/ready channel interfaces for the input level and the result scale
// depends on pwli_pkg for the field widths
interface pwli_level_if;
  import pwli_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level_percent;

  modport source (output valid, output level_percent, input ready);
  modport sink (input valid, input level_percent, output ready);
endinterface

interface pwli_scale_if;
  import pwli_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] scale_out;

  modport source (output valid, output scale_out, input ready);
  modport sink (input valid, input scale_out, output ready);
endinterface

// File: sv/piecewise_linear_interpolator.sv
// Piecewise linear interpolator: maps a signed Q8.8 percentage to a Q12.8
// scale through a table of up to MAX_POINTS breakpoints.
//
// Channels: level (sink) carries level_percent, scale (source) carries
// scale_out; a transaction moves at a clock edge with valid and ready high.
// Configuration: cfg_write with cfg_index 0 = point count, 1 = default
// scale, 2.. = breakpoints; write only while no item is in flight.
//
// Timing: level.ready is high only in the idle state. After a transaction,
// the search visits one breakpoint per cycle, 1..MAX_POINTS in all.
// A constant answer goes from the search to the finish state, which loads
// the result and sets scale.valid; an interpolated one first passes the
// multiply state and the divide state, where the serial divider works out
// one quotient bit a cycle. The next transaction can be taken in the cycle
// after the result loads; no new item is taken while one is in flight.
// The result sits in an output register: while the receiver stalls, the
// block takes and works on the next item and holds it before the output.
// Reset: point count 0, default scale 100.0, breakpoints 0, no result.
module piecewise_linear_interpolator
  import pwli_pkg::*;
#(
  parameter int MAX_POINTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pwli_level_if.sink           level,
  pwli_scale_if.source         scale
);

  pwli_cmd_t  cmd;
  pwli_stat_t stat;

  // sequencing
  pwli_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .level_valid (level.valid),
    .level_ready (level.ready),
    .scale_valid (scale.valid),
    .scale_ready (scale.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // arithmetic and configuration
  pwli_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .level_percent (level.level_percent),
    .cmd           (cmd),
    .stat          (stat),
    .scale_out     (scale.scale_out)
  );

endmodule

// File: sv/pwli_dp.sv
// datapath: configuration registers, segment search, multiplier,
// restoring divider and result register; depends on pwli_pkg
module pwli_dp
  import pwli_pkg::*;
#(
  parameter int MAX_POINTS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic signed [LEVEL_W-1:0] level_percent,
  input  pwli_cmd_t                 cmd,
  output pwli_stat_t                stat,
  output logic [SCALE_W-1:0]        scale_out
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_POINTS);

  // configuration
  logic [CNT_W-1:0]   point_count;
  logic [SCALE_W-1:0] default_scale;
  logic [PCT_W-1:0]   pt_pct   [MAX_POINTS];
  logic [SCALE_W-1:0] pt_scale [MAX_POINTS];

  // working registers
  logic [PCT_Q_W-1:0]   p;
  logic [IDX_W-1:0]     idx;
  logic [PCT_W-1:0]     prev_pct;
  logic [SCALE_W-1:0]   prev_scale;
  logic [SCALE_W-1:0]   lo;
  logic                 neg;
  logic [SCALE_W-1:0]   mag;
  logic [PCT_Q_W-1:0]   num;
  logic [PCT_Q_W-1:0]   den;
  logic [PCT_Q_W-1:0]   rem;
  logic [SCALE_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  // combinational
  logic [CNT_W-1:0]   n_eff;
  logic [PCT_W-1:0]   cur_pct;
  logic [SCALE_W-1:0] cur_scale;
  logic [PCT_Q_W-1:0] cur_q;
  logic [PCT_Q_W-1:0] prev_q;
  logic               is_first;
  logic               is_last;
  logic               found_const;
  logic               found_lerp;
  logic [SCALE_W-1:0] const_val;
  logic [SCALE_W-1:0] lerp_lo;
  logic [SCALE_W-1:0] lerp_hi;
  logic [PCT_Q_W-1:0] lerp_num;
  logic [PCT_Q_W-1:0] lerp_den;
  logic [PCT_Q_W-1:0] p_clamped;
  logic [PCT_Q_W:0]   shifted;
  logic [PCT_Q_W+1:0] trial;
  logic [PROD_W-1:0]  product;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      default_scale <= DEFAULT_SCALE_RST;
      for (int k = 0; k < MAX_POINTS; k++) begin
        pt_pct[k]   <= '0;
        pt_scale[k] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_POINT_COUNT) begin
        point_count <= cfg_data[CNT_W-1:0];
      end
      if (cfg_index == REG_DEFAULT_SCALE) begin
        default_scale <= cfg_data[SCALE_W-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_POINT_BASE) + k)) begin
          pt_pct[k]   <= cfg_data[PCT_W-1:0];
          pt_scale[k] <= cfg_data[PT_SCALE_LSB +: SCALE_W];
        end
      end
    end
  end

  // clamp input to 0..100 percent
  always_comb begin
    priority if (level_percent[LEVEL_W-1]) begin
      p_clamped = '0;
    end else if (level_percent[PCT_Q_W-1:0] > HUNDRED_Q8) begin
      p_clamped = HUNDRED_Q8;
    end else begin
      p_clamped = level_percent[PCT_Q_W-1:0];
    end
  end

  // segment check for the current breakpoint
  assign n_eff     = (point_count > MAX_N) ? MAX_N : point_count;
  assign cur_pct   = pt_pct[idx];
  assign cur_scale = pt_scale[idx];
  assign cur_q     = {cur_pct, {FRAC_W{1'b0}}};
  assign prev_q    = {prev_pct, {FRAC_W{1'b0}}};
  assign is_first  = (idx == '0);
  assign is_last   = (CNT_W'(idx) == n_eff - CNT_W'(1));

  always_comb begin
    found_const = 1'b0;
    found_lerp  = 1'b0;
    const_val   = cur_scale;
    lerp_lo     = prev_scale;
    lerp_hi     = cur_scale;
    lerp_num    = p - prev_q;
    lerp_den    = cur_q - prev_q;
    priority if (n_eff == '0) begin
      found_const = 1'b1;
      const_val   = default_scale;
    end else if (is_first) begin
      // ramp from the default scale at zero percent
      lerp_lo  = default_scale;
      lerp_num = p;
      lerp_den = cur_q;
      priority if (p <= cur_q) begin
        if (cur_pct == '0) begin
          found_const = 1'b1;
        end else begin
          found_lerp = 1'b1;
        end
      end else if (is_last) begin
        found_const = 1'b1;
      end else begin
        // not here, go on to the next breakpoint
      end
    end else begin
      priority if (p >= prev_q && p <= cur_q) begin
        if (cur_q <= prev_q) begin
          found_const = 1'b1;
        end else begin
          found_lerp = 1'b1;
        end
      end else if (is_last) begin
        found_const = 1'b1;
      end else begin
        // not in this segment, go on to the next one
      end
    end
  end

  // one restoring division step
  assign shifted = {rem, quo[SCALE_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};
  assign product = PROD_W'(mag) * PROD_W'(num);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p   <= p_clamped;
      idx <= '0;
    end
    // search one breakpoint a cycle
    if (cmd.search) begin
      priority if (found_const) begin
        lo  <= const_val;
        neg <= 1'b0;
        quo <= '0;
      end else if (found_lerp) begin
        lo  <= lerp_lo;
        neg <= (lerp_hi < lerp_lo);
        mag <= (lerp_hi < lerp_lo) ? lerp_lo - lerp_hi : lerp_hi - lerp_lo;
        num <= lerp_num;
        den <= lerp_den;
      end else begin
        prev_pct   <= cur_pct;
        prev_scale <= cur_scale;
        idx        <= idx + IDX_W'(1);
      end
    end
    // product feeds the divider directly; its top part is below den
    if (cmd.mult) begin
      {rem, quo} <= product;
      div_cnt    <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[PCT_Q_W+1]) begin
        rem <= trial[PCT_Q_W-1:0];
        quo <= {quo[SCALE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[PCT_Q_W-1:0];
        quo <= {quo[SCALE_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    // result register
    if (cmd.finish) begin
      scale_out <= neg ? lo - quo : lo + quo;
    end
  end

  assign stat.found_const = found_const;
  assign stat.found_lerp  = found_lerp;
  assign stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

// File: sv/pwli_ctrl.sv
// controller: sequences search, multiply, divide and result hand-off
// depends on pwli_pkg for the command and status structs
module pwli_ctrl
  import pwli_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       level_valid,
  output logic       level_ready,
  output logic       scale_valid,
  input  logic       scale_ready,
  input  pwli_stat_t stat,
  output pwli_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  // commands decoded from state and the channel handshakes
  assign level_ready  = (state == ST_IDLE);
  assign cmd.start    = (state == ST_IDLE) && level_valid;
  assign cmd.search   = (state == ST_SEARCH);
  assign cmd.mult     = (state == ST_MULT);
  assign cmd.div_step = (state == ST_DIVIDE);
  assign cmd.finish   = (state == ST_FINISH) && (!scale_valid || scale_ready);

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scale_valid <= 1'b0;
    end else begin
      // set on a new result, cleared when its transaction goes out
      if (cmd.finish) begin
        scale_valid <= 1'b1;
      end else if (scale_valid && scale_ready) begin
        scale_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (level_valid) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          priority if (stat.found_const) begin
            state <= ST_FINISH;
          end else if (stat.found_lerp) begin
            state <= ST_MULT;
          end else begin
            // keep searching
          end
        end
        ST_MULT: begin
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (stat.div_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/pwli_checker.sv
// port-level checks for the piecewise linear interpolator
// depends on pwli_pkg; bound to the top level at the end of this file
module pwli_checker
  import pwli_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               level_valid,
  input logic               level_ready,
  input logic               scale_valid,
  input logic               scale_ready,
  input logic [SCALE_W-1:0] scale_out
);

  // one item at a time: busy after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (level_valid && level_ready) |=> !level_ready)
    else $error("level.ready stayed high after a transaction");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(scale_valid) |-> $past(!level_ready))
    else $error("result appeared without work in progress");

  // the block is idle again once its result is loaded
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(scale_valid) |-> level_ready)
    else $error("block not idle after loading a result");

  // reset empties the output and returns to idle
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!scale_valid && level_ready))
    else $error("reset did not clear the block");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (scale_valid && !scale_ready) |=> (scale_valid && $stable(scale_out)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_interpolator pwli_checker u_pwli_checker (
  .clk         (clk),
  .rst         (rst),
  .level_valid (level.valid),
  .level_ready (level.ready),
  .scale_valid (scale.valid),
  .scale_ready (scale.ready),
  .scale_out   (scale.scale_out)
);
